// File: hdl/mp2a_pkg.sv
// Shared types and constants for the 2-D max pooling block with argmax.
// No dependencies; imported by mp2a_pos, mp2a_update and max_pool_2d_argmax.
`default_nettype none
package mp2a_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int INDEX_BITS   = 26;
    localparam int DIM_BITS     = 11;
    localparam int CH_BITS      = 7;
    localparam int K_BITS       = 5;
    localparam int WIN_BITS     = K_BITS - 1;
    localparam int PLANE_BITS   = CH_BITS - 1;
    localparam int MAX_HEIGHT   = 1024;
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_WINDOW   = 16;
    localparam int ENTRY_BITS   = INDEX_BITS + SAMPLE_BITS;

    typedef enum logic [1:0] {
        REG_WIDTH    = 2'd0,
        REG_HEIGHT   = 2'd1,
        REG_CHANNELS = 2'd2,
        REG_WINDOW   = 2'd3
    } t_reg_idx;

    // clamped geometry
    typedef struct packed {
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
        logic [CH_BITS-1:0]  c;
        logic [K_BITS-1:0]   k;
    } t_geom;

    // one sample with its window bookkeeping
    typedef struct packed {
        logic                          hit;
        logic                          first;
        logic                          emit;
        logic                          last;
        logic [INDEX_BITS-1:0]         idx;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_slot;

endpackage
`default_nettype wire

// File: hdl/mp2a_colmem.sv
// Per-column running maximum and argmax store, one write and one read port.
// Registered read data.
`default_nettype none
module mp2a_colmem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 42
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/mp2a_pos.sv
// Stream position tracker: column, row, plane, window offsets and flat index.
// Produces the window bookkeeping for the sample at the input. Uses mp2a_pkg.
`default_nettype none
module mp2a_pos #(
    parameter int AW = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mp2a_pkg::t_geom i_geom,
    input  wire logic          i_restart,
    input  wire logic          i_advance,
    input  wire logic [mp2a_pkg::SAMPLE_BITS-1:0] i_sample,
    output mp2a_pkg::t_slot    o_slot,
    output logic      [AW-1:0] o_addr
);
    import mp2a_pkg::*;

    localparam int XB = DIM_BITS + 1;

    logic [DIM_BITS-1:0]   r_col, n_col, r_row, n_row;
    logic [DIM_BITS-1:0]   r_cbase, n_cbase, r_rbase, n_rbase;
    logic [PLANE_BITS-1:0] r_plane, n_plane;
    logic [WIN_BITS-1:0]   r_iwc, n_iwc, r_iwr, n_iwr;
    logic [AW-1:0]         r_ocol, n_ocol;
    logic [INDEX_BITS-1:0] r_idx, n_idx;

    logic [XB-1:0] k_x, w_x, h_x, cb_x, rb_x;
    logic col_fit, row_fit, col_tail, row_tail;
    logic iwc_last, iwr_last, plane_last, col_end, row_end;

    always_comb begin
        k_x   = {{(XB-K_BITS){1'b0}}, i_geom.k};
        w_x   = {1'b0, i_geom.w};
        h_x   = {1'b0, i_geom.h};
        cb_x  = {1'b0, r_cbase};
        rb_x  = {1'b0, r_rbase};
        col_fit  = (cb_x + k_x) <= w_x;
        row_fit  = (rb_x + k_x) <= h_x;
        col_tail = (cb_x + (k_x << 1)) > w_x;
        row_tail = (rb_x + (k_x << 1)) > h_x;
        iwc_last = ({1'b0, r_iwc} + K_BITS'(1)) >= i_geom.k;
        iwr_last = ({1'b0, r_iwr} + K_BITS'(1)) >= i_geom.k;
        plane_last = ({1'b0, r_plane} + CH_BITS'(1)) >= i_geom.c;
        col_end  = ({1'b0, r_col} + XB'(1)) >= w_x;
        row_end  = ({1'b0, r_row} + XB'(1)) >= h_x;

        o_slot.hit    = col_fit && row_fit;
        o_slot.first  = (r_iwc == '0) && (r_iwr == '0);
        o_slot.emit   = col_fit && row_fit && iwc_last && iwr_last;
        o_slot.last   = o_slot.emit && plane_last && row_tail && col_tail;
        o_slot.idx    = r_idx;
        o_slot.sample = i_sample;
        o_addr        = r_ocol;
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_cbase = r_cbase;
        n_rbase = r_rbase;
        n_plane = r_plane;
        n_iwc   = r_iwc;
        n_iwr   = r_iwr;
        n_ocol  = r_ocol;
        n_idx   = r_idx + INDEX_BITS'(1);
        if (col_end) begin
            n_col   = '0;
            n_iwc   = '0;
            n_ocol  = '0;
            n_cbase = '0;
            if (row_end) begin
                n_row   = '0;
                n_iwr   = '0;
                n_rbase = '0;
                if (plane_last) begin
                    n_plane = '0;
                    n_idx   = '0;
                end else begin
                    n_plane = r_plane + PLANE_BITS'(1);
                end
            end else begin
                n_row = r_row + DIM_BITS'(1);
                if (iwr_last) begin
                    n_iwr   = '0;
                    n_rbase = r_rbase + DIM_BITS'(i_geom.k);
                end else begin
                    n_iwr = r_iwr + WIN_BITS'(1);
                end
            end
        end else begin
            n_col = r_col + DIM_BITS'(1);
            if (iwc_last) begin
                n_iwc   = '0;
                n_ocol  = r_ocol + AW'(1);
                n_cbase = r_cbase + DIM_BITS'(i_geom.k);
            end else begin
                n_iwc = r_iwc + WIN_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col   <= '0;
            r_row   <= '0;
            r_cbase <= '0;
            r_rbase <= '0;
            r_plane <= '0;
            r_iwc   <= '0;
            r_iwr   <= '0;
            r_ocol  <= '0;
            r_idx   <= '0;
        end else if (i_advance) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_cbase <= n_cbase;
            r_rbase <= n_rbase;
            r_plane <= n_plane;
            r_iwc   <= n_iwc;
            r_iwr   <= n_iwr;
            r_ocol  <= n_ocol;
            r_idx   <= n_idx;
        end
    end

endmodule
`default_nettype wire

// File: hdl/mp2a_update.sv
// Read-modify-write of the column store, compare stage with forwarding,
// and the output register. Uses mp2a_pkg and mp2a_colmem.
`default_nettype none
module mp2a_update #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire mp2a_pkg::t_slot i_slot,
    input  wire logic [AW-1:0] i_addr,
    output logic               o_adv,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [mp2a_pkg::SAMPLE_BITS-1:0] o_out_max,
    output logic [mp2a_pkg::INDEX_BITS-1:0]  o_out_arg,
    output logic               o_out_last
);
    import mp2a_pkg::*;

    t_slot                   r_s1;
    logic                    r_s1_v;
    logic [AW-1:0]           r_s1_addr;
    logic                    r_fwd;
    logic [ENTRY_BITS-1:0]   r_fwd_data;
    logic                    r_out_v;
    logic [SAMPLE_BITS-1:0]  r_out_max;
    logic [INDEX_BITS-1:0]   r_out_arg;
    logic                    r_out_last;

    logic                    accept, we, take;
    logic [ENTRY_BITS-1:0]   rdata, old_entry, new_entry;

    assign o_adv  = !(r_s1_v && r_s1.emit && r_out_v && !i_out_ready);
    assign accept = i_in_valid && o_adv;
    assign we     = o_adv && r_s1_v && r_s1.hit;

    mp2a_colmem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (ENTRY_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s1_addr),
        .i_wdata (new_entry),
        .i_re    (accept),
        .i_raddr (i_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        old_entry = r_fwd ? r_fwd_data : rdata;
        take = r_s1.first ||
               (r_s1.sample > $signed(old_entry[SAMPLE_BITS-1:0]));
        new_entry = take ? {r_s1.idx, r_s1.sample} : old_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
        end else if (o_adv) begin
            r_s1_v <= accept;
            // entry being written now is read by the next item
            r_fwd  <= accept && i_slot.hit && r_s1_v && r_s1.hit && (i_addr == r_s1_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s1       <= i_slot;
            r_s1_addr  <= i_addr;
            r_fwd_data <= new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (o_adv && r_s1_v && r_s1.emit) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && r_s1_v && r_s1.emit) begin
            r_out_max  <= new_entry[SAMPLE_BITS-1:0];
            r_out_arg  <= new_entry[ENTRY_BITS-1:SAMPLE_BITS];
            r_out_last <= r_s1.last;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_max   = r_out_max;
    assign o_out_arg   = r_out_arg;
    assign o_out_last  = r_out_last;

endmodule
`default_nettype wire

// File: hdl/max_pool_2d_argmax.sv
// K-by-K max pooling, stride K, with argmax, over a channel-by-channel raster
// stream. One sample is accepted every clock unless the input stalls. The
// window's pooled item passes from the compare stage to the output register.
// Input stalls only while a finished item waits in the output register and
// the next one is ready to leave the compare stage. The column store is one
// memory read at the sample's column and written back from the compare
// stage, with forwarding of the value in flight; it needs no clearing pass
// after reset. Uses mp2a_pkg, mp2a_pos, mp2a_update, mp2a_colmem.
`default_nettype none
module max_pool_2d_argmax #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [15:0] pooled_value, [41:16] source_index
    output logic             m_axis_tlast    // last_of_image
);
    import mp2a_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [DIM_BITS:0] MAX_W_X = (DIM_BITS+1)'(MAX_WIDTH);
    localparam logic [DIM_BITS:0] MAX_H_X = (DIM_BITS+1)'(MAX_HEIGHT);
    localparam logic [CH_BITS:0]  MAX_C_X = (CH_BITS+1)'(MAX_CHANNELS);
    localparam logic [K_BITS:0]   MAX_K_X = (K_BITS+1)'(MAX_WINDOW);

    logic [DIM_BITS-1:0] r_width, r_height;
    logic [CH_BITS-1:0]  r_chans;
    logic [K_BITS-1:0]   r_win;

    logic     cfg_wr, restart;
    t_reg_idx reg_idx;
    t_geom    geom;
    t_slot    slot;
    logic [AW-1:0] addr;
    logic     adv;
    logic [SAMPLE_BITS-1:0] out_max;
    logic [INDEX_BITS-1:0]  out_arg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_BITS'(64);
            r_height <= DIM_BITS'(64);
            r_chans  <= CH_BITS'(1);
            r_win    <= K_BITS'(2);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_WIDTH:    r_width  <= pwdata[DIM_BITS-1:0];
                REG_HEIGHT:   r_height <= pwdata[DIM_BITS-1:0];
                REG_CHANNELS: r_chans  <= pwdata[CH_BITS-1:0];
                REG_WINDOW:   r_win    <= pwdata[K_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        restart = 1'b0;
        prdata  = '0;
        case (reg_idx)
            REG_WIDTH: begin
                restart = cfg_wr;
                prdata  = {{(32-DIM_BITS){1'b0}}, r_width};
            end
            REG_HEIGHT: begin
                restart = cfg_wr;
                prdata  = {{(32-DIM_BITS){1'b0}}, r_height};
            end
            REG_CHANNELS: begin
                restart = cfg_wr;
                prdata  = {{(32-CH_BITS){1'b0}}, r_chans};
            end
            REG_WINDOW: begin
                restart = cfg_wr;
                prdata  = {{(32-K_BITS){1'b0}}, r_win};
            end
            default: ;
        endcase
    end

    // zero counts as one, large values clamp to the maxima
    always_comb begin
        geom.w = (r_width == '0) ? DIM_BITS'(1) :
                 ({1'b0, r_width} > MAX_W_X) ? MAX_W_X[DIM_BITS-1:0] : r_width;
        geom.h = (r_height == '0) ? DIM_BITS'(1) :
                 ({1'b0, r_height} > MAX_H_X) ? MAX_H_X[DIM_BITS-1:0] : r_height;
        geom.c = (r_chans == '0) ? CH_BITS'(1) :
                 ({1'b0, r_chans} > MAX_C_X) ? MAX_C_X[CH_BITS-1:0] : r_chans;
        geom.k = (r_win == '0) ? K_BITS'(1) :
                 ({1'b0, r_win} > MAX_K_X) ? MAX_K_X[K_BITS-1:0] : r_win;
    end

    mp2a_pos #(
        .AW (AW)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_restart (restart),
        .i_advance (s_axis_tvalid && adv),
        .i_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_slot    (slot),
        .o_addr    (addr)
    );

    mp2a_update #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_slot      (slot),
        .i_addr      (addr),
        .o_adv       (adv),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_max   (out_max),
        .o_out_arg   (out_arg),
        .o_out_last  (m_axis_tlast)
    );

    assign s_axis_tready = adv;
    assign m_axis_tdata  = {{(48-ENTRY_BITS){1'b0}}, out_arg, out_max};

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        restart |=> (slot.first && addr == '0 && slot.idx == '0))
        else $error("position not cleared after register write");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a held output item");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        slot.last |-> (slot.emit && slot.hit))
        else $error("image end flagged on a sample that closes no window");

endmodule
`default_nettype wire
